/* rtl/alrs_pkg.sv */
// Shared types and constants for the length-prefixed record scanner.
`timescale 1ns / 1ps

package alrs_pkg;

    // Stream geometry
    localparam int PAYLOAD_MAX = 4096;  // cap on the effective payload length
    localparam int LEN_W       = 13;    // payload_length / byte counter width
    localparam int OFF_W       = 12;    // reported offset width
    localparam int SIZE_W      = 14;    // decoded size width
    localparam int VER_W       = 7;     // decoded version width
    localparam int NAME_W      = 48;    // target name width
    localparam int HPOS_W      = 4;     // header position counter width

    // Header layout
    localparam int HDR_LEN     = 12;
    localparam int NAME_LEN    = 6;
    localparam int SIZE_POS    = 8;

    localparam logic [LEN_W-1:0] OFFSET_SAT = {LEN_W{1'b1}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_NAME    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_OVERRUN   = 2'd2,
        ST_BAD_SIZE  = 2'd3
    } status_t;

    // One payload byte as held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    // One result request toward the output register
    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [OFF_W-1:0]  block_offset;
        logic [SIZE_W-1:0] block_size;
        logic [VER_W-1:0]  block_version;
    } result_t;

endpackage

/* rtl/ascii_length_record_scanner_unit.sv */
// Top level of the length-prefixed record scanner.
`timescale 1ns / 1ps

//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, data_byte, last             | sink
//  out     | out_valid, out_ready, status, block_offset,     | source
//          | block_size, block_version                       |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | sink
//
//  One payload byte per clock while the output register can take a result:
//  a byte is held in the input register, then the record logic updates its
//  state and loads the output register. rst_n (async, active low) clears
//  all stream state and both registers. A stalled output holds the input
//  register and the record logic; while the output is drained each cycle,
//  bytes keep flowing at full rate.
//  Config writes are always taken (cfg_ready tied high).
//
//  Records: 12-byte header (6 name, 2 version digits, 4 size digits), the
//  size covering the header. The first header that gives a verdict ends the
//  scan; if none does by the last byte, a not-found request is emitted.

module ascii_length_record_scanner_unit
    import alrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 last,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [OFF_W-1:0]     block_offset,
    output logic [SIZE_W-1:0]    block_size,
    output logic [VER_W-1:0]     block_version,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NAME_W-1:0]    cfg_data
);

    item_t   item;
    result_t res;
    logic    advance;

    assign cfg_ready = 1'b1;

    // input register
    alrs_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last      (last),
        .advance   (advance),
        .item      (item)
    );

    // header parse, size checks and name compare
    alrs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .advance   (advance),
        .res       (res)
    );

    // result register
    alrs_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_offset  (block_offset),
        .block_size    (block_size),
        .block_version (block_version)
    );

endmodule

/* rtl/alrs_in_stage.sv */
// Input register for payload bytes.
`timescale 1ns / 1ps

module alrs_in_stage
    import alrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last,
    input  logic       advance,
    output item_t      item
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // take a new byte when empty or when the held one moves on
    assign in_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            last_reg <= last;
        end
    end

    assign item.valid     = valid_reg;
    assign item.data_byte = byte_reg;
    assign item.last      = last_reg;

endmodule

/* rtl/alrs_core.sv */
// Record walk state, configuration registers and per-byte decision logic.
`timescale 1ns / 1ps

module alrs_core
    import alrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NAME_W-1:0]    cfg_data,
    input  item_t                item,
    input  logic                 advance,
    output result_t              res
);

    logic [NAME_W-1:0] target_name_reg;
    logic [LEN_W-1:0]  payload_length_reg;

    logic [LEN_W-1:0]  byte_offset_reg,  byte_offset_next;
    logic [LEN_W-1:0]  record_start_reg, record_start_next;
    logic [SIZE_W-1:0] skip_reg,         skip_next;
    logic [HPOS_W-1:0] hdr_pos_reg,      hdr_pos_next;
    logic              name_match_reg,   name_match_next;
    logic [SIZE_W-1:0] size_acc_reg,     size_acc_next;
    logic [VER_W-1:0]  ver_acc_reg,      ver_acc_next;
    logic [1:0]        digits_ok_reg,    digits_ok_next;
    logic              reported_reg,     reported_next;

    logic              fire;
    logic [LEN_W-1:0]  eff_len;

    assign fire    = item.valid && advance;
    assign eff_len = (payload_length_reg > LEN_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX)
                                                               : payload_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_name_reg    <= '0;
            payload_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_NAME:    target_name_reg    <= cfg_data;
                CFG_PAYLOAD_LENGTH: payload_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        logic              digit;
        logic [3:0]        dval;
        logic [2:0]        npos;
        logic [7:0]        want;
        logic [SIZE_W-1:0] sz;
        logic [VER_W-1:0]  ver;
        logic [LEN_W:0]    hdr_end;
        logic [SIZE_W:0]   rec_end;

        byte_offset_next  = byte_offset_reg;
        record_start_next = record_start_reg;
        skip_next         = skip_reg;
        hdr_pos_next      = hdr_pos_reg;
        name_match_next   = name_match_reg;
        size_acc_next     = size_acc_reg;
        ver_acc_next      = ver_acc_reg;
        digits_ok_next    = digits_ok_reg;
        reported_next     = reported_reg;
        res               = '0;

        digit   = (item.data_byte >= 8'h30) && (item.data_byte <= 8'h39);
        dval    = item.data_byte[3:0];
        npos    = hdr_pos_reg[2:0];
        want    = target_name_reg[8*(NAME_LEN-1-int'(npos)) +: 8];
        hdr_end = {1'b0, byte_offset_reg} + (LEN_W+1)'(HDR_LEN);
        sz      = '0;
        ver     = '0;
        rec_end = '0;

        if (fire)
        begin
            if (!reported_reg)
            begin
                if (skip_reg != '0)
                begin
                    skip_next = skip_reg - SIZE_W'(1);
                end
                else if (hdr_pos_reg != '0 || hdr_end < {1'b0, eff_len})
                begin
                    if (hdr_pos_reg == '0)
                    begin
                        record_start_next = byte_offset_reg;
                        name_match_next   = 1'b1;
                        size_acc_next     = '0;
                        ver_acc_next      = '0;
                        digits_ok_next    = 2'b11;
                        want              = target_name_reg[NAME_W-1 -: 8];
                    end
                    if (hdr_pos_reg < HPOS_W'(NAME_LEN))
                    begin
                        if (want != item.data_byte)
                            name_match_next = 1'b0;
                    end
                    else if (hdr_pos_reg < HPOS_W'(SIZE_POS))
                    begin
                        if (digit)
                            ver_acc_next = VER_W'(ver_acc_next * VER_W'(10)
                                                  + VER_W'(dval));
                        else
                            digits_ok_next[0] = 1'b0;
                    end
                    else
                    begin
                        if (digit)
                            size_acc_next = SIZE_W'(size_acc_next * SIZE_W'(10)
                                                    + SIZE_W'(dval));
                        else
                            digits_ok_next[1] = 1'b0;
                    end
                    hdr_pos_next = hdr_pos_reg + HPOS_W'(1);

                    if (hdr_pos_reg == HPOS_W'(HDR_LEN - 1))
                    begin
                        ver          = digits_ok_next[0] ? ver_acc_next  : '0;
                        sz           = digits_ok_next[1] ? size_acc_next : '0;
                        rec_end      = (SIZE_W+1)'(record_start_reg) + (SIZE_W+1)'(sz);
                        hdr_pos_next = '0;
                        res.block_offset  = record_start_reg[OFF_W-1:0];
                        res.block_size    = sz;
                        res.block_version = ver;
                        if (!digits_ok_next[1] || sz < SIZE_W'(HDR_LEN))
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_BAD_SIZE;
                        end
                        else if (rec_end > (SIZE_W+1)'(eff_len))
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_OVERRUN;
                        end
                        else if (name_match_next)
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_FOUND;
                        end
                        else
                        begin
                            skip_next = sz - SIZE_W'(HDR_LEN);
                        end
                        if (res.valid)
                            reported_next = 1'b1;
                    end
                end
            end

            if (byte_offset_reg != OFFSET_SAT)
                byte_offset_next = byte_offset_reg + LEN_W'(1);

            if (item.last)
            begin
                if (!reported_next)
                begin
                    res        = '0;
                    res.valid  = 1'b1;
                    res.status = ST_NOT_FOUND;
                end
                byte_offset_next  = '0;
                record_start_next = '0;
                skip_next         = '0;
                hdr_pos_next      = '0;
                name_match_next   = 1'b1;
                size_acc_next     = '0;
                ver_acc_next      = '0;
                digits_ok_next    = 2'b11;
                reported_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= '0;
            record_start_reg <= '0;
            skip_reg         <= '0;
            hdr_pos_reg      <= '0;
            name_match_reg   <= 1'b1;
            size_acc_reg     <= '0;
            ver_acc_reg      <= '0;
            digits_ok_reg    <= 2'b11;
            reported_reg     <= 1'b0;
        end
        else
        begin
            byte_offset_reg  <= byte_offset_next;
            record_start_reg <= record_start_next;
            skip_reg         <= skip_next;
            hdr_pos_reg      <= hdr_pos_next;
            name_match_reg   <= name_match_next;
            size_acc_reg     <= size_acc_next;
            ver_acc_reg      <= ver_acc_next;
            digits_ok_reg    <= digits_ok_next;
            reported_reg     <= reported_next;
        end
    end

    // results only come from a byte that moves through
    a_res_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> fire)
        else $error("result without a consumed byte");

    // header position never runs past the header
    a_hdr_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg < HPOS_W'(HDR_LEN))
        else $error("header position out of range");

    // skipping and header parsing are exclusive
    a_skip_vs_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg != '0 |-> hdr_pos_reg == '0)
        else $error("skip while inside a header");

    // last byte clears the stream state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last |=> byte_offset_reg == '0 && !reported_reg
                              && hdr_pos_reg == '0 && skip_reg == '0)
        else $error("stream state not cleared after last");

endmodule

/* rtl/alrs_out_stage.sv */
// Output register holding one result request until it is taken.
`timescale 1ns / 1ps

module alrs_out_stage
    import alrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  result_t           res,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [OFF_W-1:0]  block_offset,
    output logic [SIZE_W-1:0] block_size,
    output logic [VER_W-1:0]  block_version
);

    logic              valid_reg;
    status_t           status_reg;
    logic [OFF_W-1:0]  offset_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [VER_W-1:0]  version_reg;

    // room for a new result when empty or being drained this cycle
    assign advance = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            status_reg  <= res.status;
            offset_reg  <= res.block_offset;
            size_reg    <= res.block_size;
            version_reg <= res.block_version;
        end
    end

    assign out_valid     = valid_reg;
    assign status        = status_reg;
    assign block_offset  = offset_reg;
    assign block_size    = size_reg;
    assign block_version = version_reg;

endmodule

/* verif/ascii_length_record_scanner_unit_test.sv */
// Self-checking testbench for the length-prefixed record scanner.
`timescale 1ns / 1ps

module ascii_length_record_scanner_unit_test;
    import alrs_pkg::*;

    // Watchdog for a run of about 600 bytes in short payloads, with idling on
    // both sides and a drain wait before each register write.
    localparam int CYCLE_LIMIT = 40000;
    localparam int ITEM_TARGET = 600;   // payload bytes sent over the whole run
    localparam int IDLE_PCT    = 22;    // percent of cycles a side holds off
    localparam int DRAIN_WAIT  = 4;     // wait for the input and output registers to run empty

    typedef logic [7:0] octet_t;

    // One expected scan verdict
    typedef struct {
        status_t            status;
        logic [OFF_W-1:0]   offset;
        logic [SIZE_W-1:0]  size;
        logic [VER_W-1:0]   version;
    } scan_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           status;
    logic [OFF_W-1:0]     block_offset;
    logic [SIZE_W-1:0]    block_size;
    logic [VER_W-1:0]     block_version;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TARGET_NAME;
    logic [NAME_W-1:0]    cfg_data = '0;

    ascii_length_record_scanner_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_offset  (block_offset),
        .block_size    (block_size),
        .block_version (block_version),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Scanner model: register copies plus the per-stream walk state.
    // ------------------------------------------------------------------
    logic [NAME_W-1:0] target_reg;
    logic [LEN_W-1:0]  length_reg;

    logic [LEN_W-1:0]  offset_ctr;      // saturating byte position
    logic [LEN_W-1:0]  rec_start;       // start of the header being read
    logic [SIZE_W-1:0] skip_left;       // body bytes of a skipped record
    logic [HPOS_W-1:0] hdr_idx;         // next header byte index, 0 = idle
    logic              name_ok;
    logic [SIZE_W-1:0] size_acc;
    logic [VER_W-1:0]  ver_acc;
    logic [1:0]        digit_ok;        // bit 0 version digits, bit 1 size digits
    logic              scan_done;       // a verdict went out for this payload

    scan_report_t pending_reports[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  sent_bytes = 0;
    bit  steady = 1'b0;                 // when set, neither side idles

    function automatic void clear_scan();
        offset_ctr = '0;
        rec_start  = '0;
        skip_left  = '0;
        hdr_idx    = '0;
        name_ok    = 1'b1;
        size_acc   = '0;
        ver_acc    = '0;
        digit_ok   = 2'b11;
        scan_done  = 1'b0;
    endfunction

    // Advance the walk by one accepted payload byte and queue any verdict.
    function automatic void track_byte(octet_t b, logic is_last);
        int           eff_len;
        int           d;
        int           sz;
        bit           is_digit;
        scan_report_t r;

        eff_len  = (length_reg > PAYLOAD_MAX) ? PAYLOAD_MAX : length_reg;
        is_digit = (b >= 8'h30) && (b <= 8'h39);
        d        = int'(b) - 8'h30;

        if (!scan_done)
        begin
            if (skip_left > 0)
            begin
                skip_left = skip_left - 1'b1;
            end
            else if (hdr_idx > 0 || offset_ctr + HDR_LEN < eff_len)
            begin
                if (hdr_idx == 0)
                begin
                    rec_start = offset_ctr;
                    name_ok   = 1'b1;
                    size_acc  = '0;
                    ver_acc   = '0;
                    digit_ok  = 2'b11;
                end
                if (hdr_idx < NAME_LEN)
                begin
                    // first name byte sits in the top byte of the target
                    if (target_reg[40 - 8 * hdr_idx +: 8] != b)
                        name_ok = 1'b0;
                end
                else if (hdr_idx < SIZE_POS)
                begin
                    if (is_digit)
                        ver_acc = VER_W'(ver_acc * 10 + d);
                    else
                        digit_ok[0] = 1'b0;
                end
                else
                begin
                    if (is_digit)
                        size_acc = SIZE_W'(size_acc * 10 + d);
                    else
                        digit_ok[1] = 1'b0;
                end

                if (hdr_idx == HDR_LEN - 1)
                begin
                    hdr_idx   = '0;
                    sz        = digit_ok[1] ? size_acc : 0;
                    r.offset  = rec_start[OFF_W-1:0];
                    r.size    = SIZE_W'(sz);
                    r.version = digit_ok[0] ? ver_acc : '0;
                    // size check, then overrun, then name
                    if (!digit_ok[1] || sz < HDR_LEN)
                    begin
                        r.status  = ST_BAD_SIZE;
                        scan_done = 1'b1;
                    end
                    else if (rec_start + sz > eff_len)
                    begin
                        r.status  = ST_OVERRUN;
                        scan_done = 1'b1;
                    end
                    else if (name_ok)
                    begin
                        r.status  = ST_FOUND;
                        scan_done = 1'b1;
                    end
                    else
                    begin
                        skip_left = SIZE_W'(sz - HDR_LEN);
                    end
                    if (scan_done)
                        pending_reports.push_back(r);
                end
                else
                begin
                    hdr_idx = hdr_idx + 1'b1;
                end
            end
        end

        if (offset_ctr != OFFSET_SAT)
            offset_ctr = offset_ctr + 1'b1;

        if (is_last)
        begin
            if (!scan_done)
            begin
                r.status  = ST_NOT_FOUND;
                r.offset  = '0;
                r.size    = '0;
                r.version = '0;
                pending_reports.push_back(r);
            end
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic check_report();
        scan_report_t want;

        if (pending_reports.size() == 0)
        begin
            flag_mismatch($sformatf("result with none expected: status %0d offset %0d",
                                    status, block_offset));
            return;
        end
        want = pending_reports.pop_front();
        if (status != want.status)
            flag_mismatch($sformatf("status %0d, expected %s", status, want.status.name()));
        if (block_offset != want.offset)
            flag_mismatch($sformatf("block_offset %0d, expected %0d", block_offset,
                                    want.offset));
        if (block_size != want.size)
            flag_mismatch($sformatf("block_size %0d, expected %0d", block_size, want.size));
        if (block_version != want.version)
            flag_mismatch($sformatf("block_version %0d, expected %0d", block_version,
                                    want.version));
    endtask

    // Output side: handshake sampled on the pre-edge values, then a fresh
    // ready decision for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_report();
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ascii_length_record_scanner_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task starts and returns in the time step of a rising edge.
    // ------------------------------------------------------------------

    // Send one payload byte as a request; the model sees it on acceptance.
    task automatic send_byte(input octet_t b, input logic is_last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= is_last;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sent_bytes++;
        track_byte(b, is_last);
    endtask

    // Whole payload, last flagged on its final byte.
    task automatic send_payload(input octet_t pay[$]);
        foreach (pay[i])
            send_byte(pay[i], i == pay.size() - 1);
        in_valid <= 1'b0;
    endtask

    // Wait until every verdict is back, then let the pipeline run empty:
    // a payload byte that yields no verdict may still be in flight.
    task automatic settle();
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NAME_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_TARGET_NAME)
            target_reg = value;
        else
            length_reg = value[LEN_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Payload builders
    // ------------------------------------------------------------------
    function automatic octet_t ascii_digit(int v);
        return octet_t'(8'h30 + v % 10);
    endfunction

    function automatic logic [NAME_W-1:0] random_name();
        return NAME_W'({$urandom, $urandom});
    endfunction

    // 12 header bytes only: name, two version digits, four size digits.
    function automatic void append_header(ref octet_t pay[$], input logic [NAME_W-1:0] name,
                                          input int version, input int size);
        for (int i = 0; i < NAME_LEN; i++)
            pay.push_back(name[40 - 8 * i +: 8]);
        pay.push_back(ascii_digit(version / 10));
        pay.push_back(ascii_digit(version));
        pay.push_back(ascii_digit(size / 1000));
        pay.push_back(ascii_digit(size / 100));
        pay.push_back(ascii_digit(size / 10));
        pay.push_back(ascii_digit(size));
    endfunction

    // Header plus random body up to the stated size.
    function automatic void append_record(ref octet_t pay[$], input logic [NAME_W-1:0] name,
                                          input int version, input int size);
        append_header(pay, name, version, size);
        for (int i = HDR_LEN; i < size; i++)
            pay.push_back(octet_t'($urandom));
    endfunction

    function automatic void append_noise(ref octet_t pay[$], input int count);
        repeat (count) pay.push_back(octet_t'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Match in the first record, bad version digits, all-ones and all-zero names.
    task automatic test_found_first();
        octet_t pay[$];

        write_reg(CFG_TARGET_NAME, "U_HEAD");
        write_reg(CFG_PAYLOAD_LENGTH, 20);
        append_record(pay, "U_HEAD", 1, 20);
        send_payload(pay);

        pay = {};
        append_record(pay, "U_HEAD", 99, 20);
        pay[6] = "A";                           // version no longer two digits
        send_payload(pay);

        write_reg(CFG_TARGET_NAME, '1);
        pay = {};
        append_record(pay, '1, 57, 20);
        send_payload(pay);

        write_reg(CFG_TARGET_NAME, '0);
        pay = {};
        append_record(pay, '0, 0, 20);
        send_payload(pay);
    endtask

    // Non-matching record is skipped; match at the minimum size of 12.
    task automatic test_skip_to_next();
        octet_t pay[$];

        write_reg(CFG_TARGET_NAME, "U_HEAD");
        write_reg(CFG_PAYLOAD_LENGTH, 26);
        append_record(pay, "U_TLAY", 3, 13);
        append_record(pay, "U_HEAD", 4, 12);
        append_noise(pay, 1);
        send_payload(pay);
    endtask

    // Non-digit in the size field, size below a header, size zero.
    task automatic test_bad_size();
        octet_t pay[$];

        write_reg(CFG_PAYLOAD_LENGTH, 20);
        append_record(pay, "U_HEAD", 12, 20);
        pay[10] = "A";
        send_payload(pay);

        pay = {};
        append_header(pay, "U_HEAD", 12, 11);
        append_noise(pay, 8);
        send_payload(pay);

        pay = {};
        append_header(pay, "U_HEAD", 12, 0);
        append_noise(pay, 8);
        send_payload(pay);
    endtask

    // Record runs past the payload end; bytes after the verdict are ignored.
    task automatic test_overrun();
        octet_t pay[$];

        write_reg(CFG_PAYLOAD_LENGTH, 4096);
        append_header(pay, "U_HEAD", 42, 9999);
        append_noise(pay, 18);
        send_payload(pay);

        write_reg(CFG_PAYLOAD_LENGTH, 30);
        pay = {};
        append_header(pay, "U_HEAD", 42, 31);
        append_noise(pay, 18);
        send_payload(pay);
    endtask

    // A header needs more than 12 bytes left; an empty length parses nothing.
    task automatic test_header_room();
        octet_t pay[$];

        write_reg(CFG_PAYLOAD_LENGTH, 12);
        append_header(pay, "U_HEAD", 5, 12);
        send_payload(pay);

        write_reg(CFG_PAYLOAD_LENGTH, 13);
        pay = {};
        append_record(pay, "U_HEAD", 5, 13);
        send_payload(pay);

        write_reg(CFG_PAYLOAD_LENGTH, 0);
        pay = {};
        append_header(pay, "U_HEAD", 5, 12);
        append_noise(pay, 4);
        send_payload(pay);
    endtask

    // last disagrees with the length: early cut mid-header, bytes past the end.
    task automatic test_last_mismatch();
        octet_t pay[$];

        write_reg(CFG_PAYLOAD_LENGTH, 40);
        append_record(pay, "U_HEAD", 7, 40);
        send_payload(pay[0:6]);
        send_payload(pay);                      // stream state starts clean again

        write_reg(CFG_PAYLOAD_LENGTH, 20);
        pay = {};
        append_record(pay, "U_TLAY", 7, 14);
        append_record(pay, "U_HEAD", 7, 20);    // starts too late to be read
        append_noise(pay, 6);
        send_payload(pay);
    endtask

    // Length cap at PAYLOAD_MAX and a verdict on the last byte.
    task automatic test_length_cap();
        octet_t pay[$];

        write_reg(CFG_PAYLOAD_LENGTH, 5000);
        append_header(pay, "U_HEAD", 10, 4097);
        append_noise(pay, 8);
        send_payload(pay);

        write_reg(CFG_PAYLOAD_LENGTH, 4096);
        pay = {};
        append_header(pay, "U_HEAD", 10, 4096);
        send_payload(pay);
    endtask

    // Mostly well-formed record chains with random content, some corruption,
    // some pure noise, lengths and last placement sometimes off.
    task automatic test_random_payloads();
        octet_t            pay[$];
        logic [NAME_W-1:0] name;
        int                first_byte;
        int                start;
        int                size;
        int                total;
        int                len;
        int                k;

        first_byte = sent_bytes;
        write_reg(CFG_TARGET_NAME, random_name());
        while (sent_bytes < ITEM_TARGET)
        begin
            // long stretch at full rate
            steady = (sent_bytes - first_byte >= 40) && (sent_bytes - first_byte < 160);
            if ($urandom_range(9) < 3)
                write_reg(CFG_TARGET_NAME, random_name());

            pay = {};
            if ($urandom_range(99) < 10)
            begin
                append_noise(pay, $urandom_range(1, 40));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(2))
                        0: name = target_reg;
                        1:
                        begin
                            // near miss: one bit off in one name byte
                            name = target_reg;
                            k    = 8 * $urandom_range(NAME_LEN - 1);
                            name[k +: 8] = name[k +: 8] ^ octet_t'(1 << $urandom_range(7));
                        end
                        default: name = random_name();
                    endcase
                    size  = ($urandom_range(9) == 0) ? $urandom_range(HDR_LEN - 1)
                                                     : $urandom_range(HDR_LEN, 24);
                    start = pay.size();
                    append_record(pay, name, $urandom_range(99), size);
                    if ($urandom_range(19) == 0)
                        pay[start + $urandom_range(NAME_LEN, SIZE_POS - 1)] = octet_t'($urandom);
                    if ($urandom_range(19) == 0)
                        pay[start + $urandom_range(SIZE_POS, HDR_LEN - 1)] = octet_t'($urandom);
                end
            end

            total = pay.size();
            case ($urandom_range(19))
                0, 1:    len = $urandom_range(total);
                2, 3:    len = total + $urandom_range(1, 30);
                4:       len = $urandom_range(PAYLOAD_MAX, OFFSET_SAT);
                default: len = total;
            endcase
            if (len != length_reg)
                write_reg(CFG_PAYLOAD_LENGTH, NAME_W'(len));

            if ($urandom_range(9) == 0)
                pay = pay[0:$urandom_range(total - 1)];
            else if ($urandom_range(9) == 0)
                append_noise(pay, $urandom_range(1, 20));

            send_payload(pay);
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        target_reg = '0;
        length_reg = '0;
        clear_scan();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_found_first();
        test_skip_to_next();
        test_bad_size();
        test_overrun();
        test_header_room();
        test_last_mismatch();
        test_length_cap();
        test_random_payloads();

        settle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("ascii_length_record_scanner_unit regression: pass");
        else
            $display("ascii_length_record_scanner_unit regression: fail");
        $finish;
    end

endmodule
